// ===== rtl/dpsg_pkg.sv =====
// ----------------------------------------------------------------------------
// Dual PSG package
// Shared types, constants and the volume curve table.
// ----------------------------------------------------------------------------
package dpsg_pkg;

    localparam logic [1:0] OP_SELECT = 2'd0;
    localparam logic [1:0] OP_WRITE  = 2'd1;
    localparam logic [1:0] OP_READ   = 2'd2;
    localparam logic [1:0] OP_TICK   = 2'd3;

    localparam logic [1:0] CFG_TURBO = 2'd0;
    localparam logic [1:0] CFG_SWAP  = 2'd1;
    localparam logic [1:0] CFG_CURVE = 2'd2;

    localparam logic [31:0] LFSR_TAPS  = 32'hea000001;
    localparam logic [31:0] LFSR_TOP   = 32'h80000000;
    localparam logic [7:0]  SEL_FIRST  = 8'hFE;
    localparam logic [7:0]  SEL_SECOND = 8'hFF;
    localparam logic [7:0]  NOISE_MASK = 8'h38;
    localparam logic [7:0]  VOL_MASK   = 8'h1f;
    localparam int          CURVES_IN_ROM = 5;

    localparam logic [3:0] REG_NOISE  = 4'd6;
    localparam logic [3:0] REG_MIXER  = 4'd7;
    localparam logic [3:0] REG_VOL_A  = 4'd8;
    localparam logic [3:0] REG_VOL_B  = 4'd9;
    localparam logic [3:0] REG_VOL_C  = 4'd10;
    localparam logic [3:0] REG_ENV_LO = 4'd11;
    localparam logic [3:0] REG_ENV_HI = 4'd12;
    localparam logic [3:0] REG_SHAPE  = 4'd13;
    localparam logic [3:0] REG_PORT_A = 4'd14;
    localparam logic [3:0] REG_PORT_B = 4'd15;

    // Result item fields.
    typedef struct packed {
        logic       levels_valid;
        logic       level_chip;
        logic [5:0] level_c;
        logic [5:0] level_b;
        logic [5:0] level_a;
        logic [7:0] read_data;
    } result_t;

    // Volume curve table, index by curve and then by volume.
    function automatic logic [5:0] curve_level(input logic [2:0] curve, input logic [3:0] v);
        logic [5:0] r;
        r = 6'd0;
        case (curve)
            3'd1:
            begin
                case (v)
                    4'd0: r = 6'd0;  4'd1: r = 6'd1;  4'd2: r = 6'd2;  4'd3: r = 6'd3;
                    4'd4: r = 6'd4;  4'd5: r = 6'd5;  4'd6: r = 6'd6;  4'd7: r = 6'd8;
                    4'd8: r = 6'd10; 4'd9: r = 6'd12; 4'd10: r = 6'd16; 4'd11: r = 6'd19;
                    4'd12: r = 6'd23; 4'd13: r = 6'd28; 4'd14: r = 6'd34; default: r = 6'd40;
                endcase
            end
            3'd2:
            begin
                case (v)
                    4'd0: r = 6'd0;  4'd1: r = 6'd1;  4'd2: r = 6'd2;  4'd3: r = 6'd2;
                    4'd4: r = 6'd3;  4'd5: r = 6'd3;  4'd6: r = 6'd4;  4'd7: r = 6'd6;
                    4'd8: r = 6'd7;  4'd9: r = 6'd9;  4'd10: r = 6'd12; 4'd11: r = 6'd15;
                    4'd12: r = 6'd19; 4'd13: r = 6'd25; 4'd14: r = 6'd32; default: r = 6'd41;
                endcase
            end
            3'd3:
            begin
                case (v)
                    4'd0: r = 6'd0;  4'd1: r = 6'd3;  4'd2: r = 6'd5;  4'd3: r = 6'd8;
                    4'd4: r = 6'd11; 4'd5: r = 6'd13; 4'd6: r = 6'd16; 4'd7: r = 6'd19;
                    4'd8: r = 6'd21; 4'd9: r = 6'd24; 4'd10: r = 6'd27; 4'd11: r = 6'd29;
                    4'd12: r = 6'd32; 4'd13: r = 6'd35; 4'd14: r = 6'd37; default: r = 6'd40;
                endcase
            end
            3'd4:
            begin
                case (v)
                    4'd0: r = 6'd0;  4'd1: r = 6'd10; 4'd2: r = 6'd15; 4'd3: r = 6'd20;
                    4'd4: r = 6'd23; 4'd5: r = 6'd27; 4'd6: r = 6'd29; 4'd7: r = 6'd31;
                    4'd8: r = 6'd32; 4'd9: r = 6'd33; 4'd10: r = 6'd35; 4'd11: r = 6'd36;
                    4'd12: r = 6'd38; 4'd13: r = 6'd39; 4'd14: r = 6'd40; default: r = 6'd40;
                endcase
            end
            default:
            begin
                case (v)
                    4'd0: r = 6'd0;  4'd1: r = 6'd2;  4'd2: r = 6'd4;  4'd3: r = 6'd5;
                    4'd4: r = 6'd7;  4'd5: r = 6'd8;  4'd6: r = 6'd9;  4'd7: r = 6'd11;
                    4'd8: r = 6'd12; 4'd9: r = 6'd14; 4'd10: r = 6'd16; 4'd11: r = 6'd19;
                    4'd12: r = 6'd23; 4'd13: r = 6'd28; 4'd14: r = 6'd34; default: r = 6'd40;
                endcase
            end
        endcase
        return r;
    endfunction

endpackage

// ===== rtl/dual_psg_sound_generator_core.sv =====
// ----------------------------------------------------------------------------
// Dual PSG sound generator core
// Two three-voice sound generators with register bus items and tick items.
// ----------------------------------------------------------------------------
//  channel | direction | tdata / payload
//  s_axis  | in        | opcode, data_byte, chip_index, tick_delta
//  m_axis  | out       | read_data, level_a/b/c, level_chip, levels_valid
//  cfg     | in        | cfg_index, cfg_data (turbo, swap, curve)
//
// An accepted transaction is held in the input register and processed by the
// chip state logic in a single pass at the next edge, which writes its result
// into a two-entry output buffer, from which the result is offered. One item
// per cycle is sustained while the consumer keeps up. The input is held off
// when the input register and the buffer together already hold two items and
// the consumer takes none in that cycle.
// Reset is asynchronous and clears the chip state, the configuration and the
// buffer occupancy to their power-on values.
module dual_psg_sound_generator_core #(
    parameter int NUM_CHIPS  = 2,
    parameter int NUM_CURVES = 5
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // opcode[1:0], data_byte[9:2], chip_index[10], tick_delta[18:11], zeros
    input  logic [23:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // read_data[7:0], level_a[13:8], level_b[19:14], level_c[25:20],
    // level_chip[26], levels_valid[27], zeros
    output logic [31:0] m_axis_tdata,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [7:0]  cfg_data
);
    import dpsg_pkg::*;

    localparam int NV = NUM_CHIPS * 3;
    localparam int CW = (NUM_CHIPS > 1) ? $clog2(NUM_CHIPS) : 1;

    // Configuration registers.
    logic       turbo_reg, swap_reg;
    logic [2:0] curve_reg;

    // Chip state.
    logic [7:0]  sel_reg;
    logic [CW-1:0] cur_reg;
    logic [11:0] tper_reg [NV];
    logic [4:0]  nper_reg [NUM_CHIPS];
    logic [7:0]  mix_reg  [NUM_CHIPS];
    logic [4:0]  vol_reg  [NV];
    logic [15:0] eper_reg [NUM_CHIPS];
    logic [3:0]  shape_reg [NUM_CHIPS];
    logic [7:0]  pa_reg [NUM_CHIPS];
    logic [7:0]  pb_reg [NUM_CHIPS];
    logic        erst_reg [NUM_CHIPS];
    logic        tbit_reg [NV];
    logic        nbit_reg [NUM_CHIPS];
    logic [31:0] tcnt_reg [NV];
    logic [8:0]  ncnt_reg [NUM_CHIPS];
    logic [31:0] epre_reg [NUM_CHIPS];
    logic [31:0] estep_reg [NUM_CHIPS];
    logic [5:0]  elvl_reg [NUM_CHIPS];
    logic        edir_reg [NUM_CHIPS];
    logic [31:0] lfsr_reg;

    // Input register.
    logic        in_valid_reg;
    logic [18:0] in_reg;

    // Output buffer.
    result_t     obuf_reg [2];
    logic [1:0]  ocount_reg;
    logic        orptr_reg, owptr_reg;

    logic in_fire, proc, out_fire;
    result_t res;

    assign cfg_ready = 1'b1;
    // The input register may load when the buffer can still take everything in flight.
    assign s_axis_tready = (ocount_reg + {1'b0, in_valid_reg}) < 2'd2 ||
                           ((ocount_reg + {1'b0, in_valid_reg}) == 2'd2 && m_axis_tvalid && m_axis_tready);
    assign in_fire  = s_axis_tvalid && s_axis_tready;
    assign proc     = in_valid_reg;
    assign m_axis_tvalid = ocount_reg != 2'd0;
    assign out_fire = m_axis_tvalid && m_axis_tready;
    assign m_axis_tdata = {4'd0, obuf_reg[orptr_reg]};

    logic [1:0]  op;
    logic [7:0]  dbyte;
    logic [CW-1:0] tchip;
    logic [31:0] delta;
    logic [2:0]  curve;
    assign op    = in_reg[1:0];
    assign dbyte = in_reg[9:2];
    assign tchip = (int'(in_reg[10]) < NUM_CHIPS) ? CW'(in_reg[10]) : CW'(NUM_CHIPS - 1);
    assign delta = {24'd0, in_reg[18:11]};
    assign curve = (int'(curve_reg) < NUM_CURVES && int'(curve_reg) < CURVES_IN_ROM) ?
                   curve_reg : 3'd0;

    // Register read path.
    logic [7:0] rd;
    logic [3:0] rn;
    assign rn = sel_reg[3:0];
    always_comb
    begin
        rd = 8'd0;
        if (sel_reg < 8'd16)
        begin
            case (rn)
                4'd0, 4'd2, 4'd4: rd = tper_reg[int'(cur_reg) * 3 + int'(rn[2:1])][7:0];
                4'd1, 4'd3, 4'd5: rd = {4'd0, tper_reg[int'(cur_reg) * 3 + int'(rn[2:1])][11:8]};
                REG_NOISE:  rd = {3'd0, nper_reg[cur_reg]};
                REG_MIXER:  rd = mix_reg[cur_reg];
                REG_VOL_A:  rd = {3'd0, vol_reg[int'(cur_reg) * 3]};
                REG_VOL_B:  rd = {3'd0, vol_reg[int'(cur_reg) * 3 + 1]};
                REG_VOL_C:  rd = {3'd0, vol_reg[int'(cur_reg) * 3 + 2]};
                REG_ENV_LO: rd = eper_reg[cur_reg][7:0];
                REG_ENV_HI: rd = eper_reg[cur_reg][15:8];
                REG_SHAPE:  rd = {4'd0, shape_reg[cur_reg]};
                REG_PORT_A: rd = pa_reg[cur_reg];
                default:    rd = pb_reg[cur_reg];
            endcase
        end
    end

    // Tick path for the chip named by the tick item.
    logic [7:0]  mix;
    logic        vbit [3];
    logic [31:0] tsum [3];
    logic [31:0] tnew [3];
    logic        tflip [3];
    logic [8:0]  nsum;
    logic        nfire, nrun, nbit_new;
    logic [31:0] lfsr_new;
    logic        erun;
    logic [31:0] epre_a, epre_new, estep_new, span;
    logic        edir_a, edir_new, estep_fire;
    logic [5:0]  elvl_new;
    logic [5:0]  lvl [3];
    logic [3:0]  es;
    logic        early;
    logic [4:0]  vv;

    always_comb
    begin
        mix = mix_reg[tchip];
        for (int v = 0; v < 3; v++)
        begin
            vbit[v]  = tbit_reg[int'(tchip) * 3 + v];
            tsum[v]  = tcnt_reg[int'(tchip) * 3 + v] + delta;
            tflip[v] = 1'b0;
            tnew[v]  = tsum[v];
            if (!mix[v])
            begin
                if (tsum[v] >= {20'd0, tper_reg[int'(tchip) * 3 + v]} &&
                    {20'd0, tper_reg[int'(tchip) * 3 + v]} >= delta)
                begin
                    tflip[v] = 1'b1;
                    tnew[v]  = tsum[v] - {20'd0, tper_reg[int'(tchip) * 3 + v]};
                end
            end
            else
            begin
                vbit[v] = 1'b1;
                tnew[v] = 32'd0;
            end
        end

        // Noise counter and shared shift register.
        nrun     = (~mix & NOISE_MASK) != 8'd0;
        nsum     = ncnt_reg[tchip] + delta[8:0];
        nfire    = nrun && ({1'b0, nsum} >= {4'd0, nper_reg[tchip], 1'b0});
        nbit_new = nbit_reg[tchip];
        lfsr_new = lfsr_reg;
        if (nfire)
        begin
            nbit_new = lfsr_reg[0];
            lfsr_new = lfsr_reg[0] ? (((lfsr_reg ^ LFSR_TAPS) >> 1) | LFSR_TOP) : (lfsr_reg >> 1);
        end
        if (nrun && !nbit_new)
        begin
            for (int v = 0; v < 3; v++)
            begin
                if (!mix[3 + v])
                begin
                    vbit[v] = 1'b0;
                end
            end
        end

        // Envelope.
        erun = ((vol_reg[int'(tchip) * 3] | vol_reg[int'(tchip) * 3 + 1] |
                 vol_reg[int'(tchip) * 3 + 2]) & 5'h10) != 5'd0;
        span      = {15'd0, eper_reg[tchip], 1'b0};
        epre_a    = erst_reg[tchip] ? 32'd0 : epre_reg[tchip] + delta;
        edir_a    = erst_reg[tchip] ? 1'b1 : edir_reg[tchip];
        estep_new = erst_reg[tchip] ? 32'd0 : estep_reg[tchip];
        estep_fire = epre_a >= span;
        epre_new  = epre_a;
        edir_new  = edir_a;
        elvl_new  = elvl_reg[tchip];
        es        = 4'd0;
        early     = 1'b0;
        if (estep_fire)
        begin
            estep_new = estep_new + 32'd1;
            epre_new  = epre_a - span;
            if (estep_new[3:0] == 4'd0)
            begin
                edir_new = !edir_a;
            end
            es    = estep_new[3:0];
            early = estep_new < 32'd16;
            case (shape_reg[tchip])
                4'd0, 4'd1, 4'd2, 4'd3, 4'd9:
                    elvl_new = early ? curve_level(curve, ~es) : curve_level(curve, 4'd0);
                4'd4, 4'd5, 4'd6, 4'd7, 4'd15:
                    elvl_new = early ? curve_level(curve, es) : curve_level(curve, 4'd0);
                4'd8:  elvl_new = curve_level(curve, ~es);
                4'd12: elvl_new = curve_level(curve, es);
                4'd10: elvl_new = edir_new ? curve_level(curve, ~es) : curve_level(curve, es);
                4'd14: elvl_new = edir_new ? curve_level(curve, es) : curve_level(curve, ~es);
                4'd11: elvl_new = early ? curve_level(curve, ~es) : curve_level(curve, 4'd15);
                default: elvl_new = early ? curve_level(curve, es) : curve_level(curve, 4'd15);
            endcase
        end

        // Voice levels.
        for (int v = 0; v < 3; v++)
        begin
            vv = vol_reg[int'(tchip) * 3 + v];
            lvl[v] = 6'd0;
            if (vbit[v])
            begin
                lvl[v] = vv[4] ? (erun ? elvl_new : elvl_reg[tchip]) : curve_level(curve, vv[3:0]);
            end
        end

        res = '0;
        if (op == OP_READ)
        begin
            res.read_data = rd;
        end
        else if (op == OP_TICK)
        begin
            res.level_a = lvl[0];
            res.level_b = lvl[1];
            res.level_c = lvl[2];
            res.level_chip = in_reg[10] & (NUM_CHIPS > 1);
            res.levels_valid = 1'b1;
        end
    end

    // Control and output buffer.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
            ocount_reg   <= 2'd0;
            orptr_reg    <= 1'b0;
            owptr_reg    <= 1'b0;
            turbo_reg    <= 1'b0;
            swap_reg     <= 1'b0;
            curve_reg    <= 3'd0;
        end
        else
        begin
            if (in_fire)
            begin
                in_valid_reg <= 1'b1;
            end
            else if (proc)
            begin
                in_valid_reg <= 1'b0;
            end
            if (proc)
            begin
                owptr_reg <= !owptr_reg;
            end
            if (out_fire)
            begin
                orptr_reg <= !orptr_reg;
            end
            ocount_reg <= ocount_reg + {1'b0, proc} - {1'b0, out_fire};
            if (cfg_valid)
            begin
                case (cfg_index)
                    CFG_TURBO: turbo_reg <= cfg_data[0];
                    CFG_SWAP:  swap_reg  <= cfg_data[0];
                    CFG_CURVE: curve_reg <= cfg_data[2:0];
                    default:   ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            in_reg <= s_axis_tdata[18:0];
        end
        if (proc)
        begin
            obuf_reg[owptr_reg] <= res;
        end
    end

    // Chip state update.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sel_reg  <= 8'd0;
            cur_reg  <= '0;
            lfsr_reg <= 32'd1;
            for (int i = 0; i < NV; i++)
            begin
                tper_reg[i] <= 12'd0;
                vol_reg[i]  <= 5'd0;
                tbit_reg[i] <= 1'b0;
                tcnt_reg[i] <= 32'd0;
            end
            for (int c = 0; c < NUM_CHIPS; c++)
            begin
                nper_reg[c]  <= 5'd0;
                mix_reg[c]   <= 8'hff;
                eper_reg[c]  <= 16'd0;
                shape_reg[c] <= 4'd0;
                pa_reg[c]    <= 8'hff;
                pb_reg[c]    <= 8'd0;
                erst_reg[c]  <= 1'b0;
                nbit_reg[c]  <= 1'b0;
                ncnt_reg[c]  <= 9'd0;
                epre_reg[c]  <= 32'd0;
                estep_reg[c] <= 32'd0;
                elvl_reg[c]  <= 6'd0;
                edir_reg[c]  <= 1'b1;
            end
        end
        else if (proc)
        begin
            case (op)
                OP_SELECT:
                begin
                    sel_reg <= dbyte;
                    if (!turbo_reg)
                    begin
                        cur_reg <= '0;
                    end
                    else if (dbyte == SEL_FIRST)
                    begin
                        cur_reg <= (swap_reg && NUM_CHIPS > 1) ? CW'(1) : CW'(0);
                    end
                    else if (dbyte == SEL_SECOND)
                    begin
                        cur_reg <= (!swap_reg && NUM_CHIPS > 1) ? CW'(1) : CW'(0);
                    end
                end
                OP_WRITE:
                begin
                    if (sel_reg < 8'd16)
                    begin
                        case (rn)
                            4'd0, 4'd2, 4'd4:
                                tper_reg[int'(cur_reg) * 3 + int'(rn[2:1])][7:0] <= dbyte;
                            4'd1, 4'd3, 4'd5:
                                tper_reg[int'(cur_reg) * 3 + int'(rn[2:1])][11:8] <= dbyte[3:0];
                            REG_NOISE:  nper_reg[cur_reg] <= dbyte[4:0] & VOL_MASK[4:0];
                            REG_MIXER:  mix_reg[cur_reg] <= dbyte;
                            REG_VOL_A:  vol_reg[int'(cur_reg) * 3] <= dbyte[4:0] & VOL_MASK[4:0];
                            REG_VOL_B:  vol_reg[int'(cur_reg) * 3 + 1] <= dbyte[4:0] & VOL_MASK[4:0];
                            REG_VOL_C:  vol_reg[int'(cur_reg) * 3 + 2] <= dbyte[4:0] & VOL_MASK[4:0];
                            REG_ENV_LO: eper_reg[cur_reg][7:0] <= dbyte;
                            REG_ENV_HI: eper_reg[cur_reg][15:8] <= dbyte;
                            REG_SHAPE:
                            begin
                                shape_reg[cur_reg] <= dbyte[3:0];
                                erst_reg[cur_reg]  <= 1'b1;
                            end
                            REG_PORT_A: pa_reg[cur_reg] <= dbyte;
                            default:    pb_reg[cur_reg] <= dbyte;
                        endcase
                    end
                end
                OP_TICK:
                begin
                    for (int v = 0; v < 3; v++)
                    begin
                        tcnt_reg[int'(tchip) * 3 + v] <= tnew[v];
                        if (tflip[v])
                        begin
                            tbit_reg[int'(tchip) * 3 + v] <= !tbit_reg[int'(tchip) * 3 + v];
                        end
                    end
                    if (nrun)
                    begin
                        ncnt_reg[tchip] <= nfire ? 9'd0 : nsum;
                        nbit_reg[tchip] <= nbit_new;
                        lfsr_reg        <= lfsr_new;
                    end
                    if (erun)
                    begin
                        epre_reg[tchip]  <= epre_new;
                        estep_reg[tchip] <= estep_new;
                        edir_reg[tchip]  <= edir_new;
                        elvl_reg[tchip]  <= elvl_new;
                        erst_reg[tchip]  <= 1'b0;
                    end
                end
                default: ;
            endcase
        end
    end

endmodule

// ===== tb/sv/testbench.sv =====
// ----------------------------------------------------------------------------
// Dual PSG sound generator testbench
// Drives register, read and tick transactions into the core, predicts every
// result with a behavioural model of both chips and compares field by field.
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import dpsg_pkg::*;

    typedef struct packed {
        logic [7:0] tick_delta;
        logic       chip_index;
        logic [7:0] data_byte;
        logic [1:0] opcode;
    } item_t;

    typedef struct {
        logic [1:0] op;
        logic [7:0] data;
        logic       chip;
        logic [7:0] delta;
        logic       known;
        result_t    res;
    } vector_t;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [31:0] m_axis_tdata;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [1:0]  cfg_index;
    logic [7:0]  cfg_data;

    // Predictor state for both chips.
    logic        turbo_on;
    logic        swap_on;
    logic [2:0]  curve_sel;
    logic [7:0]  sel_reg;
    logic        cur_chip;
    logic [11:0] tone_per [6];
    logic [4:0]  noise_per [2];
    logic [7:0]  mixer [2];
    logic [4:0]  vol [6];
    logic [15:0] env_per [2];
    logic [3:0]  env_shape [2];
    logic [7:0]  port_a [2];
    logic [7:0]  port_b [2];
    logic        env_restart [2];
    logic        tone_ff [6];
    logic        noise_ff [2];
    logic [31:0] tone_cnt [6];
    logic [8:0]  noise_cnt [2];
    logic [31:0] env_pre [2];
    logic [31:0] env_step [2];
    logic [5:0]  env_lvl [2];
    logic        env_dir [2];
    logic [31:0] lfsr;

    result_t     expected_results[$];
    int          failures;
    bit          hold_off;

    dual_psg_sound_generator_core dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    // Clock with a 20 ns period.
    always
    begin
        clk = 1'b1;
        #10;
        clk = 1'b0;
        #10;
    end

    function automatic logic [5:0] rom_level(input logic [2:0] c, input logic [3:0] v);
        logic [5:0] t0 [16];
        logic [5:0] t1 [16];
        logic [5:0] t2 [16];
        logic [5:0] t3 [16];
        logic [5:0] t4 [16];
        t0 = '{0, 2, 4, 5, 7, 8, 9, 11, 12, 14, 16, 19, 23, 28, 34, 40};
        t1 = '{0, 1, 2, 3, 4, 5, 6, 8, 10, 12, 16, 19, 23, 28, 34, 40};
        t2 = '{0, 1, 2, 2, 3, 3, 4, 6, 7, 9, 12, 15, 19, 25, 32, 41};
        t3 = '{0, 3, 5, 8, 11, 13, 16, 19, 21, 24, 27, 29, 32, 35, 37, 40};
        t4 = '{0, 10, 15, 20, 23, 27, 29, 31, 32, 33, 35, 36, 38, 39, 40, 40};
        case (c)
            3'd1: return t1[v];
            3'd2: return t2[v];
            3'd3: return t3[v];
            3'd4: return t4[v];
            default: return t0[v];
        endcase
    endfunction

    // Envelope level for a shape, step and direction.
    function automatic logic [5:0] envelope_value(input logic [3:0] shape, input logic [31:0] step,
                                                 input logic dir, input logic [2:0] c);
        logic [3:0] s;
        logic       early;
        logic [3:0] up;
        logic [3:0] down;
        s = step[3:0];
        early = (step < 32'd16);
        up = s;
        down = 4'd15 - s;
        case (shape)
            4'd0, 4'd1, 4'd2, 4'd3, 4'd9: return early ? rom_level(c, down) : rom_level(c, 4'd0);
            4'd4, 4'd5, 4'd6, 4'd7, 4'd15: return early ? rom_level(c, up) : rom_level(c, 4'd0);
            4'd8: return rom_level(c, down);
            4'd12: return rom_level(c, up);
            4'd10: return dir ? rom_level(c, down) : rom_level(c, up);
            4'd14: return dir ? rom_level(c, up) : rom_level(c, down);
            4'd11: return early ? rom_level(c, down) : rom_level(c, 4'd15);
            default: return early ? rom_level(c, up) : rom_level(c, 4'd15);
        endcase
    endfunction

    task automatic clear_chip_state();
        sel_reg = 0;
        cur_chip = 0;
        for (int i = 0; i < 6; i++)
        begin
            tone_per[i] = 0;
            vol[i] = 0;
            tone_ff[i] = 0;
            tone_cnt[i] = 0;
        end
        for (int c = 0; c < 2; c++)
        begin
            noise_per[c] = 0;
            mixer[c] = 8'hff;
            env_per[c] = 0;
            env_shape[c] = 0;
            port_a[c] = 8'hff;
            port_b[c] = 0;
            env_restart[c] = 0;
            noise_ff[c] = 0;
            noise_cnt[c] = 0;
            env_pre[c] = 0;
            env_step[c] = 0;
            env_lvl[c] = 0;
            env_dir[c] = 1;
        end
        lfsr = 32'd1;
    endtask

    function automatic logic [7:0] register_value(input logic c, input logic [7:0] r);
        int i;
        i = c * 3 + r / 2;
        if (r < 6)
            return r[0] ? {4'd0, tone_per[i][11:8]} : tone_per[i][7:0];
        case (r)
            REG_NOISE: return {3'd0, noise_per[c]};
            REG_MIXER: return mixer[c];
            REG_VOL_A, REG_VOL_B, REG_VOL_C: return {3'd0, vol[c * 3 + r - 8]};
            REG_ENV_LO: return env_per[c][7:0];
            REG_ENV_HI: return env_per[c][15:8];
            REG_SHAPE: return {4'd0, env_shape[c]};
            REG_PORT_A: return port_a[c];
            REG_PORT_B: return port_b[c];
            default: return 8'd0;
        endcase
    endfunction

    task automatic store_register(input logic c, input logic [7:0] r, input logic [7:0] v);
        int i;
        i = c * 3 + r / 2;
        if (r < 6)
        begin
            if (r[0])
                tone_per[i][11:8] = v[3:0];
            else
                tone_per[i][7:0] = v;
        end
        else
        begin
            case (r)
                REG_NOISE: noise_per[c] = v[4:0];
                REG_MIXER: mixer[c] = v;
                REG_VOL_A, REG_VOL_B, REG_VOL_C: vol[c * 3 + r - 8] = v[4:0];
                REG_ENV_LO: env_per[c][7:0] = v;
                REG_ENV_HI: env_per[c][15:8] = v;
                REG_SHAPE:
                begin
                    env_shape[c] = v[3:0];
                    env_restart[c] = 1'b1;
                end
                REG_PORT_A: port_a[c] = v;
                REG_PORT_B: port_b[c] = v;
                default: ;
            endcase
        end
    endtask

    // Advances one chip by a delta and returns its voice levels.
    task automatic advance_chip(input logic c, input logic [7:0] d, output result_t r);
        logic [2:0]  cv;
        logic [7:0]  mix;
        logic        bits [3];
        logic [31:0] span;
        logic [31:0] d32;
        logic [5:0]  lv [3];
        int          i;
        cv = (curve_sel < CURVES_IN_ROM) ? curve_sel : 3'd0;
        mix = mixer[c];
        d32 = {24'd0, d};
        for (int v = 0; v < 3; v++)
        begin
            i = c * 3 + v;
            bits[v] = tone_ff[i];
            if (!mix[v])
            begin
                tone_cnt[i] = tone_cnt[i] + d32;
                if (tone_cnt[i] >= tone_per[i] && tone_per[i] >= d32)
                begin
                    tone_ff[i] = !tone_ff[i];
                    tone_cnt[i] = tone_cnt[i] - tone_per[i];
                end
            end
            else
            begin
                bits[v] = 1'b1;
                tone_cnt[i] = 0;
            end
        end
        if (((~mix) & NOISE_MASK) != 0)
        begin
            noise_cnt[c] = noise_cnt[c] + d;
            if ({23'd0, noise_cnt[c]} >= {26'd0, noise_per[c], 1'b0})
            begin
                if (lfsr[0])
                begin
                    lfsr = ((lfsr ^ LFSR_TAPS) >> 1) | LFSR_TOP;
                    noise_ff[c] = 1'b1;
                end
                else
                begin
                    lfsr = lfsr >> 1;
                    noise_ff[c] = 1'b0;
                end
                noise_cnt[c] = 0;
            end
            if (!noise_ff[c])
                for (int v = 0; v < 3; v++)
                    if (!mix[3 + v])
                        bits[v] = 1'b0;
        end
        if (((vol[c * 3] | vol[c * 3 + 1] | vol[c * 3 + 2]) & 5'h10) != 0)
        begin
            span = {15'd0, env_per[c], 1'b0};
            env_pre[c] = env_pre[c] + d32;
            if (env_restart[c])
            begin
                env_step[c] = 0;
                env_pre[c] = 0;
                env_restart[c] = 0;
                env_dir[c] = 1;
            end
            if (env_pre[c] >= span)
            begin
                env_step[c] = env_step[c] + 1;
                env_pre[c] = env_pre[c] - span;
                if (env_step[c][3:0] == 0)
                    env_dir[c] = !env_dir[c];
                env_lvl[c] = envelope_value(env_shape[c], env_step[c], env_dir[c], cv);
            end
        end
        for (int v = 0; v < 3; v++)
        begin
            lv[v] = 0;
            if (bits[v])
                lv[v] = vol[c * 3 + v][4] ? env_lvl[c] : rom_level(cv, vol[c * 3 + v][3:0]);
        end
        r = '0;
        r.level_a = lv[0];
        r.level_b = lv[1];
        r.level_c = lv[2];
        r.level_chip = c;
        r.levels_valid = 1'b1;
    endtask

    task automatic predict_item(input item_t it, output result_t r);
        r = '0;
        case (it.opcode)
            OP_SELECT:
            begin
                sel_reg = it.data_byte;
                if (turbo_on)
                begin
                    if (it.data_byte == SEL_FIRST)
                        cur_chip = swap_on;
                    else if (it.data_byte == SEL_SECOND)
                        cur_chip = !swap_on;
                end
                else
                    cur_chip = 0;
            end
            OP_WRITE:
                if (sel_reg < 16)
                    store_register(cur_chip, sel_reg, it.data_byte);
            OP_READ: r.read_data = register_value(cur_chip, sel_reg);
            default: advance_chip(it.chip_index, it.tick_delta, r);
        endcase
    endtask

    // Sends one item after a random gap and queues its expected result.
    // Valid stays high between items sent without a gap.
    task automatic send_item(input item_t it, input bit known, input result_t given);
        result_t r;
        int gap;
        gap = $urandom_range(0, 13);
        if ($urandom_range(0, 3) == 0)
            gap = 0;
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {5'd0, it};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        predict_item(it, r);
        if (known && r !== given)
        begin
            $error("table row disagrees with prediction: expected %h got %h", given, r);
            failures++;
        end
        expected_results.push_back(r);
    endtask

    task automatic write_config(input logic [1:0] idx, input logic [7:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        @(posedge clk);
        case (idx)
            CFG_TURBO: turbo_on = val[0];
            CFG_SWAP: swap_on = val[0];
            default: curve_sel = val[2:0];
        endcase
    endtask

    // Stops offering items and waits until every expected result has come.
    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    function automatic item_t make_item(input logic [1:0] op, input logic [7:0] d,
                                        input logic c, input logic [7:0] t);
        item_t it;
        it.opcode = op;
        it.data_byte = d;
        it.chip_index = c;
        it.tick_delta = t;
        return it;
    endfunction

    // Random item: mostly register traffic to real registers and ticks.
    function automatic item_t random_item();
        int k;
        logic [7:0] d;
        k = $urandom_range(0, 99);
        d = 8'($urandom_range(0, 255));
        if (k < 15)
        begin
            if ($urandom_range(0, 9) < 7)
                d = 8'($urandom_range(0, 15));
            else if ($urandom_range(0, 1))
                d = 8'($urandom_range(SEL_FIRST, SEL_SECOND));
            return make_item(OP_SELECT, d, 1'($urandom_range(0, 1)),
                             8'($urandom_range(0, 255)));
        end
        if (k < 40)
            return make_item(OP_WRITE, d, 1'($urandom_range(0, 1)),
                             8'($urandom_range(0, 255)));
        if (k < 50)
            return make_item(OP_READ, d, 1'($urandom_range(0, 1)),
                             8'($urandom_range(0, 255)));
        return make_item(OP_TICK, d, 1'($urandom_range(0, 1)),
                         $urandom_range(0, 1) ? 8'($urandom_range(0, 15))
                                              : 8'($urandom_range(0, 255)));
    endfunction

    // Result checker with random receiver stalls.
    initial
    begin
        result_t got;
        result_t exp;
        int stall;
        m_axis_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            stall = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 13);
            if (stall > 0 || hold_off)
            begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge clk);
                while (hold_off)
                    @(posedge clk);
            end
            m_axis_tready <= 1'b1;
            @(posedge clk);
            while (!m_axis_tvalid)
                @(posedge clk);
            got = m_axis_tdata[27:0];
            if (expected_results.size() == 0)
            begin
                $error("unexpected result %h", got);
                failures++;
            end
            else
            begin
                exp = expected_results.pop_front();
                if (got.read_data !== exp.read_data)
                begin
                    $error("read_data expected %0d actual %0d", exp.read_data, got.read_data);
                    failures++;
                end
                if (got.level_a !== exp.level_a)
                begin
                    $error("level_a expected %0d actual %0d", exp.level_a, got.level_a);
                    failures++;
                end
                if (got.level_b !== exp.level_b)
                begin
                    $error("level_b expected %0d actual %0d", exp.level_b, got.level_b);
                    failures++;
                end
                if (got.level_c !== exp.level_c)
                begin
                    $error("level_c expected %0d actual %0d", exp.level_c, got.level_c);
                    failures++;
                end
                if (got.level_chip !== exp.level_chip)
                begin
                    $error("level_chip expected %0d actual %0d", exp.level_chip, got.level_chip);
                    failures++;
                end
                if (got.levels_valid !== exp.levels_valid)
                begin
                    $error("levels_valid expected %0d actual %0d",
                           exp.levels_valid, got.levels_valid);
                    failures++;
                end
            end
        end
    end

    // Long receiver hold-off, counted here while the sender keeps going.
    initial
    begin
        hold_off = 1'b0;
        @(posedge rst_n);
        repeat (600) @(posedge clk);
        hold_off = 1'b1;
        repeat (200) @(posedge clk);
        hold_off = 1'b0;
    end

    // Main stimulus.
    initial
    begin
        vector_t rows[$];
        vector_t row;
        result_t none;
        result_t tk;
        failures = 0;
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        cfg_valid = 1'b0;
        cfg_index = CFG_TURBO;
        cfg_data = '0;
        turbo_on = 0;
        swap_on = 0;
        curve_sel = 0;
        clear_chip_state();
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        none = '0;
        tk = '0;
        tk.levels_valid = 1'b1;
        // Directed table: reset reads, register extremes, masking, ticks.
        rows = '{
            '{OP_SELECT, REG_MIXER, 0, 0, 1, none},
            '{OP_READ, 8'h00, 0, 0, 1, '{0, 0, 0, 0, 0, 8'hff}},
            '{OP_SELECT, REG_PORT_A, 0, 0, 1, none},
            '{OP_READ, 8'h00, 0, 0, 1, '{0, 0, 0, 0, 0, 8'hff}},
            '{OP_SELECT, 8'd200, 0, 0, 1, none},
            '{OP_WRITE, 8'hff, 0, 0, 1, none},
            '{OP_READ, 8'h00, 0, 0, 1, none},
            '{OP_TICK, 8'h00, 1, 8'hff, 1, '{1, 1, 0, 0, 0, 0}},
            '{OP_TICK, 8'h00, 0, 8'h00, 1, tk},
            '{OP_SELECT, REG_VOL_A, 0, 0, 1, none},
            '{OP_WRITE, 8'hff, 0, 0, 1, none},
            '{OP_READ, 8'h00, 0, 0, 1, '{0, 0, 0, 0, 0, 8'h1f}},
            '{OP_SELECT, 8'd1, 0, 0, 1, none},
            '{OP_WRITE, 8'hff, 0, 0, 1, none},
            '{OP_READ, 8'h00, 0, 0, 1, '{0, 0, 0, 0, 0, 8'h0f}},
            '{OP_SELECT, REG_VOL_B, 0, 0, 0, none},
            '{OP_WRITE, 8'h0f, 0, 0, 0, none},
            '{OP_SELECT, REG_SHAPE, 0, 0, 0, none},
            '{OP_WRITE, 8'h0a, 0, 0, 0, none},
            '{OP_SELECT, REG_MIXER, 0, 0, 0, none},
            '{OP_WRITE, 8'h00, 0, 0, 0, none},
            '{OP_TICK, 8'h00, 0, 8'd3, 0, none},
            '{OP_TICK, 8'h00, 0, 8'hff, 0, none},
            '{OP_TICK, 8'h00, 0, 8'd1, 0, none}
        };
        foreach (rows[i])
        begin
            row = rows[i];
            send_item(make_item(row.op, row.data, row.chip, row.delta), row.known, row.res);
        end

        // Random phases over configuration settings, extremes included.
        for (int ph = 0; ph < 6; ph++)
        begin
            wait_drained();
            write_config(CFG_TURBO, (ph == 0) ? 8'd0 : (ph == 5) ? 8'd1
                                                  : 8'($urandom_range(0, 1)));
            write_config(CFG_SWAP, ph[0] ? 8'd1 : 8'd0);
            write_config(CFG_CURVE, (ph == 1) ? 8'd4 : (ph == 2) ? 8'd7 : 8'(ph % 5));
            repeat (215) send_item(random_item(), 0, none);
        end
        // Sender pause until every result is in, then a short tail.
        wait_drained();
        repeat (20) send_item(random_item(), 0, none);

        wait_drained();
        repeat (10) @(posedge clk);
        if (failures == 0 && expected_results.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    // Run limit.
    initial
    begin
        #4ms;
        $display("Test completed with failures");
        $finish;
    end
endmodule

// ===== dual_psg_sound_generator_core.f =====
rtl/dpsg_pkg.sv
rtl/dual_psg_sound_generator_core.sv
tb/sv/testbench.sv
